FILE: design/bpc_pkg.sv
// Shared types and constants for the backlight power curve block.
package bpc_pkg;

  localparam int unsigned BRIGHT_W  = 8;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CMD_W     = 32;
  localparam int unsigned TARGET_W  = 3 * BRIGHT_W;
  localparam int unsigned MULA_W    = 32;
  localparam int unsigned MULB_W    = 8;
  localparam int unsigned PROD_W    = MULA_W + MULB_W;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MUL_DIGITS = MULB_W / DIGIT_W;
  localparam int unsigned DIVD_W    = 23;
  localparam int unsigned DSR_W     = 20;

  localparam int unsigned CURVE_NUM  = 100;
  localparam int unsigned CURVE_DEN  = 2779;
  localparam int unsigned SEARCH_TOP = 255;

  localparam logic [MULB_W-1:0]  SCALE_NUM = MULB_W'(CURVE_NUM);
  localparam logic [DIVD_W-1:0]  DIV_LIMIT = DIVD_W'(CURVE_DEN * 256);
  localparam logic [DSR_W-1:0]   DEN_TOP   = DSR_W'(CURVE_DEN * 128);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(255);
  localparam logic [7:0]         CMD_DCS   = 8'h51;
  localparam logic [7:0]         CMD_HDR   = 8'h15;

  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [CMD_W-1:0]   command_word;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [MULA_W-1:0] a;
    logic [MULB_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: design/bpc_in_if.sv
// Input channel: valid/ready with brightness payload.
interface bpc_in_if;
  logic          valid;
  logic          ready;
  bpc_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/bpc_out_if.sv
// Output channel: valid/ready with level and command word payload.
interface bpc_out_if;
  logic          valid;
  logic          ready;
  bpc_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/bpc_mul.sv
// Digit-serial multiplier: 32-bit by 8-bit, one 4-bit digit of b per cycle.
module bpc_mul (
  input  logic              clk,
  input  logic              rst,
  input  bpc_pkg::mul_req_t req,
  output bpc_pkg::mul_rsp_t rsp
);

  localparam int unsigned CNT_W = (bpc_pkg::MUL_DIGITS > 1) ?
                                  $clog2(bpc_pkg::MUL_DIGITS) : 1;

  logic                         busy;
  logic                         done;
  logic [CNT_W-1:0]             cnt;
  logic [bpc_pkg::PROD_W-1:0]   a_sh;
  logic [bpc_pkg::MULB_W-1:0]   b_sh;
  logic [bpc_pkg::PROD_W-1:0]   prod;
  logic [bpc_pkg::PROD_W-1:0]   partial;

  assign partial = a_sh * bpc_pkg::PROD_W'(b_sh[bpc_pkg::DIGIT_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_sh <= bpc_pkg::PROD_W'(req.a);
        b_sh <= req.b;
        prod <= '0;
      end else if (busy) begin
        prod <= prod + partial;
        a_sh <= a_sh << bpc_pkg::DIGIT_W;
        b_sh <= b_sh >> bpc_pkg::DIGIT_W;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(bpc_pkg::MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = prod;

endmodule

FILE: design/bpc_div.sv
// Restoring divider by the curve denominator, one quotient bit per cycle, clamps to 255.
module bpc_div (
  input  logic              clk,
  input  logic              rst,
  input  bpc_pkg::div_req_t req,
  output bpc_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [2:0]                    cnt;
  logic [bpc_pkg::DIVD_W-1:0]    rem;
  logic [bpc_pkg::DSR_W-1:0]     dsr;
  logic [bpc_pkg::LEVEL_W-1:0]   quo;
  logic                          fits;

  assign fits = rem >= bpc_pkg::DIVD_W'(dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= '0;
        rem <= req.dividend;
        dsr <= bpc_pkg::DEN_TOP;
        quo <= '0;
        // quotient would not fit in 8 bits: saturate right away
        if (req.dividend >= bpc_pkg::DIV_LIMIT) begin
          quo  <= bpc_pkg::LEVEL_MAX;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (fits) begin
          rem <= rem - bpc_pkg::DIVD_W'(dsr);
        end
        quo <= {quo[bpc_pkg::LEVEL_W-2:0], fits};
        dsr <= dsr >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

FILE: design/bpc_seq.sv
// Sequencer: cube of x, binary search on mid^5, scaling, output register.
module bpc_seq (
  input  logic              clk,
  input  logic              rst,
  bpc_in_if.sink            req,
  bpc_out_if.source         resp,
  output bpc_pkg::mul_req_t mreq,
  input  bpc_pkg::mul_rsp_t mrsp,
  output bpc_pkg::div_req_t dreq,
  input  bpc_pkg::div_rsp_t drsp
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_TGT  = 3'd2;
  localparam logic [2:0] ST_MID  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_SCL  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]                     state;
  logic [2:0]                     ret_state;
  logic                           waiting;
  logic [2:0]                     mul_left;
  logic [bpc_pkg::BRIGHT_W-1:0]   x;
  logic [bpc_pkg::TARGET_W-1:0]   target;
  logic [7:0]                     low;
  logic [7:0]                     high;
  logic [7:0]                     mid;
  logic [bpc_pkg::PROD_W-1:0]     acc;
  logic [bpc_pkg::MULB_W-1:0]     opnd;
  logic [bpc_pkg::LEVEL_W-1:0]    lvl;
  logic                           ovalid;
  bpc_pkg::out_t                  odata;

  logic [8:0]                     mid_sum;
  logic [7:0]                     mid_next;
  logic [7:0]                     span;
  logic [bpc_pkg::PROD_W-1:0]     target_wide;

  assign mid_sum     = {1'b0, low} + {1'b0, high};
  assign mid_next    = mid_sum[8:1];
  assign span        = high - low;
  assign target_wide = bpc_pkg::PROD_W'(target);

  assign req.ready   = (state == ST_IDLE);
  assign resp.valid  = ovalid;
  assign resp.data   = odata;

  assign mreq.start    = (state == ST_MUL) && !waiting && (mul_left != 3'd0);
  assign mreq.a        = acc[bpc_pkg::MULA_W-1:0];
  assign mreq.b        = opnd;
  assign dreq.start    = (state == ST_DIV) && !waiting;
  assign dreq.dividend = acc[bpc_pkg::DIVD_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      waiting <= 1'b0;
      ovalid  <= 1'b0;
    end else begin
      if (resp.valid && resp.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            x         <= req.data.brightness;
            acc       <= bpc_pkg::PROD_W'(req.data.brightness);
            opnd      <= req.data.brightness;
            mul_left  <= 3'd2;
            ret_state <= ST_TGT;
            low       <= 8'd0;
            high      <= 8'(bpc_pkg::SEARCH_TOP);
            waiting   <= 1'b0;
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!waiting) begin
            if (mul_left == 3'd0) begin
              state <= ret_state;
            end else begin
              waiting <= 1'b1;
            end
          end else if (mrsp.done) begin
            acc      <= mrsp.product;
            mul_left <= mul_left - 3'd1;
            waiting  <= 1'b0;
          end
        end
        ST_TGT: begin
          target <= acc[bpc_pkg::TARGET_W-1:0];
          state  <= ST_MID;
        end
        ST_MID: begin
          if (span > 8'd1) begin
            mid       <= mid_next;
            acc       <= bpc_pkg::PROD_W'(mid_next);
            opnd      <= mid_next;
            mul_left  <= 3'd4;
            ret_state <= ST_CMP;
          end else begin
            // search done, root is the last mid tried
            acc       <= bpc_pkg::PROD_W'(x);
            opnd      <= mid;
            mul_left  <= 3'd1;
            ret_state <= ST_SCL;
          end
          state <= ST_MUL;
        end
        ST_CMP: begin
          if (acc < target_wide) begin
            low   <= mid;
            state <= ST_MID;
          end else if (acc > target_wide) begin
            high  <= mid;
            state <= ST_MID;
          end else begin
            acc       <= bpc_pkg::PROD_W'(x);
            opnd      <= mid;
            mul_left  <= 3'd1;
            ret_state <= ST_SCL;
            state     <= ST_MUL;
          end
        end
        ST_SCL: begin
          opnd      <= bpc_pkg::SCALE_NUM;
          mul_left  <= 3'd1;
          ret_state <= ST_DIV;
          state     <= ST_MUL;
        end
        ST_DIV: begin
          if (!waiting) begin
            waiting <= 1'b1;
          end else if (drsp.done) begin
            lvl     <= drsp.quotient;
            waiting <= 1'b0;
            state   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!ovalid || resp.ready) begin
            ovalid             <= 1'b1;
            odata.level        <= lvl;
            odata.command_word <= {8'h00, lvl, bpc_pkg::CMD_DCS, bpc_pkg::CMD_HDR};
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/backlight_power_curve.sv
// Backlight power curve top: sequencer, digit-serial 32x8 multiplier and divider by 2779.
// At most eight search steps; the divider skips its quotient bit steps when the level
// saturates, and the search ends early when it hits an exact root. One item in flight,
// four multiplies per search step. The next input transfer is taken in the cycle after
// the result is loaded; a stalled output only holds the next item's final state until
// the output register frees. Synchronous active-high reset idles the sequencer and
// empties the output register.
module backlight_power_curve (
  input  logic       clk,
  input  logic       rst,
  bpc_in_if.sink     req,
  bpc_out_if.source  resp
);

  bpc_pkg::mul_req_t mreq;
  bpc_pkg::mul_rsp_t mrsp;
  bpc_pkg::div_req_t dreq;
  bpc_pkg::div_rsp_t drsp;

  bpc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  bpc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  bpc_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp),
    .mreq (mreq),
    .mrsp (mrsp),
    .dreq (dreq),
    .drsp (drsp)
  );

endmodule
